// ----- design/owtd_pkg.sv -----
package owtd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned RawW       = 16;
  localparam int unsigned TempW      = 19;
  localparam int unsigned ProdW      = 23;
  localparam int unsigned ScaleShift = 4;

  localparam logic [CountW-1:0] LastByteIdx = 4'd8;
  localparam logic [ByteW-1:0]  CrcPolyRefl = 8'h8C;
  localparam logic [ProdW-1:0]  ScaleMul    = 23'd100;
  localparam logic [ProdW-1:0]  RoundBias   = 23'd15;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef logic [ByteW-1:0]        byte_t;
  typedef logic [CountW-1:0]       count_t;
  typedef logic signed [TempW-1:0] temp_t;

  // reflected crc-8, one byte per call
  function automatic byte_t crc8_update(byte_t crc, byte_t data);
    byte_t v;
    v = crc ^ data;
    for (int i = 0; i < ByteW; i++) begin
      v = v[0] ? ((v >> 1) ^ CrcPolyRefl) : (v >> 1);
    end
    return v;
  endfunction

  // raw * 100 / 16 with truncation toward zero
  function automatic temp_t scale_temp(logic [RawW-1:0] raw);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] biased;
    prod   = $signed({{(ProdW-RawW){raw[RawW-1]}}, raw}) * $signed(ScaleMul);
    biased = prod[ProdW-1] ? (prod + $signed(RoundBias)) : prod;
    return temp_t'(biased[ProdW-1:ScaleShift]);
  endfunction

endpackage

// ----- design/owtd_if.sv -----
interface owtd_in_if import owtd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  frame_start;
  byte_t data_byte;

  modport source (output valid, output frame_start, output data_byte, input ready);
  modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

interface owtd_out_if import owtd_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t temperature_centi;
  logic  status;

  modport source (output valid, output temperature_centi, output status, input ready);
  modport sink   (input valid, input temperature_centi, input status, output ready);
endinterface

// ----- design/onewire_scratchpad_temp_decoder.sv -----
// Scratchpad decoder for a 1-Wire temperature sensor.
// in_i carries one scratchpad byte per transaction with a frame_start flag
// that restarts the frame at that byte. Bytes 0..7 feed a running reflected
// crc-8 (poly 0x31, init 0); bytes 0 and 1 are kept as the raw temperature.
// The ninth byte is the received crc and yields one transaction on out_o:
// status ok and temperature in hundredths of a degree, or status error and
// zero on a crc mismatch.
// Throughput: one byte per cycle unless stalled. The crc step and the
// constant scale sit between frame state registers and result register.
// Latency: the result is valid in the cycle after the ninth byte is taken.
// Reset clears the byte count, the crc and the result valid; no clearing
// pass is needed, bytes are taken from the first cycle after reset.
// When the receiver stalls the result is held in its register; bytes 0..7
// of the next frame are still taken, and only the ninth byte waits for
// the pending result to leave.
module onewire_scratchpad_temp_decoder import owtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  owtd_in_if.sink    in_i,
  owtd_out_if.source out_o
);

  count_t count_q, count_d;
  byte_t  crc_q, crc_d;
  byte_t  lo_q, lo_d;
  byte_t  hi_q, hi_d;
  logic   out_valid_q, out_valid_d;
  temp_t  temp_q, temp_d;
  logic   status_q, status_d;

  count_t cnt_eff;
  byte_t  crc_eff;
  logic   is_last;
  logic   in_acc;
  logic   out_free;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = out_free || !is_last;
  assign in_acc    = in_i.valid && in_i.ready;

  assign cnt_eff = in_i.frame_start ? '0 : count_q;
  assign crc_eff = in_i.frame_start ? '0 : crc_q;
  assign is_last = (cnt_eff >= LastByteIdx);

  always_comb begin
    count_d     = count_q;
    crc_d       = crc_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !out_o.ready;
    temp_d      = temp_q;
    status_d    = status_q;
    if (in_acc) begin
      if (!is_last) begin
        if (cnt_eff == count_t'(0)) lo_d = in_i.data_byte;
        if (cnt_eff == count_t'(1)) hi_d = in_i.data_byte;
        crc_d   = crc8_update(crc_eff, in_i.data_byte);
        count_d = cnt_eff + count_t'(1);
      end else begin
        count_d     = '0;
        crc_d       = '0;
        out_valid_d = 1'b1;
        if (crc_eff == in_i.data_byte) begin
          temp_d   = scale_temp({hi_q, lo_q});
          status_d = StatusOk;
        end else begin
          temp_d   = '0;
          status_d = StatusErr;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q   <= temp_d;
    status_q <= status_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.temperature_centi = temp_q;
  assign out_o.status            = status_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LastByteIdx)
    else $error("byte count out of range");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && is_last))
    else $error("result without a ninth byte");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == StatusErr) |-> temp_q == '0)
    else $error("error result with nonzero temperature");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last |=> count_q == '0 && crc_q == '0)
    else $error("frame state not cleared after ninth byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_last |-> out_free)
    else $error("pending result overwritten");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import owtd_pkg::*;

  localparam int unsigned CycleLimit = 60000;
  localparam int unsigned RandomBytes = 750;
  localparam int unsigned MaxWait = 5;
  localparam int unsigned TailCycles = 6;
  localparam int FillRandom = -1;

  typedef struct {
    logic  start;
    byte_t data;
    bit    drain;
  } pad_byte_t;

  typedef struct {
    temp_t temp;
    logic  status;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  owtd_in_if  in_if ();
  owtd_out_if out_if ();

  onewire_scratchpad_temp_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pad_byte_t pending_bytes[$];
  reading_t  expected_readings[$];

  // frame tracking state of the decoder
  count_t frame_pos;
  byte_t  crc_run;
  byte_t  raw_lo;
  byte_t  raw_hi;

  pad_byte_t cur_byte;
  reading_t  got_reading;
  reading_t  want_reading;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          calm_in;
  bit          calm_out;
  logic        next_ready;

  int unsigned errors;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned readings_checked;
  int unsigned crc_ok_seen;
  int unsigned crc_err_seen;
  int unsigned restarts_sent;

  function automatic byte_t crc_step(byte_t acc, byte_t d);
    byte_t r;
    logic  fb;
    r = acc;
    for (int k = 0; k < ByteW; k++) begin
      fb = r[0] ^ d[k];
      r  = {1'b0, r[ByteW-1:1]} ^ (fb ? CrcPolyRefl : '0);
    end
    return r;
  endfunction

  function automatic int unsigned draw_wait(ref bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  task automatic track_byte(pad_byte_t b);
    reading_t    r;
    logic [15:0] raw_bits;
    int          scaled;
    if (b.start) begin
      frame_pos = '0;
      crc_run   = '0;
    end
    if (frame_pos < LastByteIdx) begin
      if (frame_pos == 0) begin
        raw_lo = b.data;
      end else if (frame_pos == 1) begin
        raw_hi = b.data;
      end
      crc_run   = crc_step(crc_run, b.data);
      frame_pos = frame_pos + 1'b1;
    end else begin
      if (crc_run == b.data) begin
        raw_bits = {raw_hi, raw_lo};
        scaled   = (int'($signed(raw_bits)) * 100) / 16;
        r.temp   = temp_t'(scaled);
        r.status = StatusOk;
      end else begin
        r.temp   = '0;
        r.status = StatusErr;
      end
      expected_readings.push_back(r);
      frame_pos = '0;
      crc_run   = '0;
    end
  endtask

  task automatic add_byte(logic s, byte_t d, bit drain);
    pad_byte_t b;
    b.start = s;
    b.data  = d;
    b.drain = drain;
    pending_bytes.push_back(b);
    if (s) begin
      restarts_sent++;
    end
  endtask

  // fill < 0 gives random bytes 2..7
  task automatic add_frame(logic s, logic [15:0] raw, bit bad_crc, int fill, bit drain);
    byte_t acc;
    byte_t d;
    byte_t tail;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (i == 0) begin
        d = raw[7:0];
      end else if (i == 1) begin
        d = raw[15:8];
      end else begin
        d = (fill < 0) ? byte_t'($urandom) : byte_t'(fill);
      end
      acc = crc_step(acc, d);
      add_byte((i == 0) ? s : 1'b0, d, (i == 0) ? drain : 1'b0);
    end
    tail = acc;
    if (bad_crc) begin
      tail = ($urandom_range(0, 1) == 0) ? (acc ^ byte_t'(1 << $urandom_range(0, 7)))
                                         : (acc ^ byte_t'($urandom_range(1, 255)));
    end
    add_byte(1'b0, tail, 1'b0);
  endtask

  task automatic fill_stimulus();
    int unsigned kind;
    int unsigned len;
    int unsigned frames;
    bit          aligned;
    logic [15:0] raw;
    // directed: extremes, bad crc, restart mid-frame, no start after reset
    add_frame(1'b0, 16'h8000, 1'b0, 8'hFF, 1'b0);
    add_frame(1'b0, 16'h7FFF, 1'b1, 8'h00, 1'b0);
    add_byte(1'b1, 8'hFF, 1'b0);
    add_byte(1'b0, 8'h00, 1'b0);
    add_frame(1'b1, 16'hFFFF, 1'b0, 8'h00, 1'b1);
    add_frame(1'b0, 16'h0000, 1'b0, 8'hFF, 1'b0);

    frames  = 0;
    aligned = 1'b1;
    while (pending_bytes.size() < RandomBytes + 40) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        case ($urandom_range(0, 7))
          0, 1:    raw = 16'($signed($urandom_range(0, 96)) - 48);
          2: begin
            case ($urandom_range(0, 3))
              0:       raw = 16'h8000;
              1:       raw = 16'h7FFF;
              2:       raw = 16'hFFFF;
              default: raw = 16'h0000;
            endcase
          end
          default: raw = 16'($urandom);
        endcase
        frames++;
        add_frame(aligned ? logic'($urandom_range(0, 1)) : 1'b1, raw,
                  $urandom_range(0, 3) == 0, FillRandom, frames % 20 == 0);
        aligned = 1'b1;
      end else if (kind == 8) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          add_byte((i == 0) ? 1'b1 : 1'b0, byte_t'($urandom), 1'b0);
        end
        aligned = 1'b0;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          add_byte(logic'($urandom_range(0, 1)), byte_t'($urandom), 1'b0);
        end
        aligned = 1'b0;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.frame_start = 1'b0;
    in_if.data_byte   = '0;
    out_if.ready      = 1'b0;
    frame_pos         = '0;
    crc_run           = '0;
    raw_lo            = '0;
    raw_hi            = '0;
    fill_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_if.valid) begin
      @(posedge clk_i);
    end
    while (expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    $display("run covered %0d bytes with %0d frame restarts", bytes_sent, restarts_sent);
    $display("readings checked %0d: %0d crc ok, %0d crc mismatch",
             readings_checked, crc_ok_seen, crc_err_seen);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.frame_start <= 1'b0;
      in_if.data_byte   <= '0;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        track_byte(cur_byte);
        bytes_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain && expected_readings.size() != 0)) begin
        cur_byte = pending_bytes.pop_front();
        in_if.valid       <= 1'b1;
        in_if.frame_start <= cur_byte.start;
        in_if.data_byte   <= cur_byte.data;
        gap_left = draw_wait(calm_in);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // reading monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_reading.temp   = out_if.temperature_centi;
        got_reading.status = out_if.status;
        if (expected_readings.size() == 0) begin
          $error("unexpected reading transaction: temperature_centi %0d status %0b",
                 got_reading.temp, got_reading.status);
          errors++;
        end else begin
          want_reading = expected_readings.pop_front();
          if (got_reading.temp !== want_reading.temp) begin
            $error("temperature_centi: expected %0d, actual %0d",
                   want_reading.temp, got_reading.temp);
            errors++;
          end
          if (got_reading.status !== want_reading.status) begin
            $error("status: expected %0b, actual %0b",
                   want_reading.status, got_reading.status);
            errors++;
          end
          if (want_reading.status == StatusOk) begin
            crc_ok_seen++;
          end else begin
            crc_err_seen++;
          end
        end
        readings_checked++;
        stall_left = draw_wait(calm_out);
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_if.ready <= next_ready;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
